// ===== sv/bri_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the bicubic RGB resizer.
// Depends on nothing; every other file but bri_ram imports it.
package bri_pkg;

  localparam int MAX_SRC_DIM  = 256;
  localparam int MAX_DEST_DIM = 1024;
  localparam int STORE_DEPTH  = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int SRC_W        = 9;
  localparam int DEST_W       = 11;
  localparam int OUT_W        = 10;
  localparam int COORD_W      = $clog2(MAX_SRC_DIM);
  localparam int FRAC_W       = 16;
  localparam int INT_W        = OUT_W + COORD_W;
  localparam int POS_W        = INT_W + FRAC_W;
  localparam int PIX_W        = 24;
  localparam int VAL_W        = 34;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 8'd3;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic [SRC_W-1:0]  src_width;
    logic [SRC_W-1:0]  src_height;
    logic [DEST_W-1:0] dest_width;
    logic [DEST_W-1:0] dest_height;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] pixel_index;
    logic [PIX_W-1:0]  rgb;
    logic [POS_W-1:0]  gx;
    logic [POS_W-1:0]  gy;
  } job_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_e;
  typedef enum logic [2:0] {B_IDLE, B_READ, B_LAST, B_CUB, B_OUT} back_state_e;

endpackage

// ===== sv/bri_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bri_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end
endmodule

// ===== sv/bri_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the coordinate mapping.
// Depends on bri_pkg.
module bri_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bri_pkg::POS_W-1:0] num_i,
  input  logic [bri_pkg::DEST_W-1:0] den_i,
  output logic                      done_o,
  output logic [bri_pkg::POS_W-1:0] quot_o
);
  import bri_pkg::*;
  localparam int CNT_W = $clog2(POS_W + 1);

  logic [POS_W-1:0]  num_q;
  logic [DEST_W-1:0] rem_q, den_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              run_q, done_q;
  logic [DEST_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, num_q[POS_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(POS_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      rem_q <= fits ? DEST_W'(trial - {1'b0, den_q}) : trial[DEST_W-1:0];
      num_q <= {num_q[POS_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;
endmodule

// ===== sv/bri_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts words, maps requests to source positions, queues jobs.
// Depends on bri_pkg and bri_div.
module bri_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bri_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic [bri_pkg::ADDR_W-1:0] pixel_index_i,
  input  logic [7:0]                 red_in_i,
  input  logic [7:0]                 green_in_i,
  input  logic [7:0]                 blue_in_i,
  input  logic [bri_pkg::OUT_W-1:0]  out_x_i,
  input  logic [bri_pkg::OUT_W-1:0]  out_y_i,
  output logic                       push_o,
  output bri_pkg::job_t              job_o,
  input  logic                       full_i
);
  import bri_pkg::*;

  front_state_e state_q, state_d;
  job_t         job_q;
  logic         accept, start, done_x, done_y;
  logic [INT_W-1:0] prod_x, prod_y;
  logic [POS_W-1:0] quot_x, quot_y;
  logic [COORD_W-1:0] span_x, span_y;

  assign accept = in_valid_i && in_ready_o;
  assign start  = accept && (kind_i == KIND_REQUEST);
  assign span_x = COORD_W'(cfg_i.src_width - 1'b1);
  assign span_y = COORD_W'(cfg_i.src_height - 1'b1);
  assign prod_x = out_x_i * span_x;
  assign prod_y = out_y_i * span_y;

  bri_div u_div_x (
    .clk_i, .rst_ni, .start_i(start), .num_i({prod_x, {FRAC_W{1'b0}}}),
    .den_i(cfg_i.dest_width), .done_o(done_x), .quot_o(quot_x)
  );
  bri_div u_div_y (
    .clk_i, .rst_ni, .start_i(start), .num_i({prod_y, {FRAC_W{1'b0}}}),
    .den_i(cfg_i.dest_height), .done_o(done_y), .quot_o(quot_y)
  );

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = (kind_i == KIND_REQUEST) ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        if (done_x && done_y) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        push_o = !full_i;
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q.kind        <= kind_i;
      job_q.pixel_index <= pixel_index_i;
      job_q.rgb         <= {red_in_i, green_in_i, blue_in_i};
    end
    if (state_q == F_DIV && done_x && done_y) begin
      job_q.gx <= quot_x;
      job_q.gy <= quot_y;
    end
  end

  assign job_o = job_q;
endmodule

// ===== sv/bri_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry job queue between front and back end.
// Depends on bri_pkg.
module bri_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bri_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bri_pkg::job_t job_o
);
  import bri_pkg::*;

  job_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= job_i;
  end
endmodule

// ===== sv/bri_back.sv =====
`timescale 1ns / 1ps
// Back end: writes loads to the image store, gathers and filters requests.
// Depends on bri_pkg and bri_ram.
module bri_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bri_pkg::cfg_t cfg_i,
  input  logic          job_valid_i,
  input  bri_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    red_out_o,
  output logic [7:0]    green_out_o,
  output logic [7:0]    blue_out_o
);
  import bri_pkg::*;

  back_state_e state_q, state_d;
  logic [2:0]  pass_q;
  logic [1:0]  cnt_q, step_q, rd_n_q;
  logic        rd_vld_q;
  logic [INT_W-1:0]  gxi_q, gyi_q;
  logic [FRAC_W-1:0] tx_q, ty_q;
  logic [7:0]        samp_q [3][4];
  logic signed [VAL_W-1:0] cols_q [3][4];
  logic signed [VAL_W-1:0] a_q [3], b_q [3], c_q [3];
  logic signed [VAL_W-1:0] p [3][4];
  logic signed [VAL_W-1:0] mul_in [3];
  logic signed [VAL_W+FRAC_W:0] prod [3];
  logic signed [VAL_W-1:0] r_val [3];
  logic [7:0]  res_q [3], out_q [3];
  logic        out_vq, out_free;
  logic [FRAC_W-1:0] t_sel;
  logic [COORD_W-1:0] px, py;
  logic [ADDR_W:0]    idx;
  logic [PIX_W-1:0]   rd_data;
  logic        wr_en;

  function automatic logic [COORD_W-1:0] clamp(input logic [INT_W-1:0] base,
                                               input logic [1:0] off,
                                               input logic [SRC_W-1:0] dim);
    logic signed [INT_W+1:0] v;
    v = $signed({2'b00, base}) + $signed({{INT_W{1'b0}}, off}) - (INT_W+2)'(1);
    if (v < 0) return '0;
    if (v > $signed({{(INT_W+2-SRC_W){1'b0}}, dim}) - (INT_W+2)'(1))
      return COORD_W'(dim - 1'b1);
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [7:0] sat8(input logic signed [VAL_W-1:0] r);
    if (r < 0) return 8'd0;
    if (r[VAL_W-1:FRAC_W+8] != '0) return 8'd255;
    return r[FRAC_W+7:FRAC_W];
  endfunction

  assign px  = clamp(gxi_q, pass_q[1:0], cfg_i.src_width);
  assign py  = clamp(gyi_q, cnt_q, cfg_i.src_height);
  assign idx = py * cfg_i.src_width + px;
  assign wr_en = (state_q == B_IDLE) && job_valid_i && (job_i.kind == KIND_LOAD);
  assign out_free = !out_vq || out_ready_i;
  assign t_sel = pass_q[2] ? tx_q : ty_q;

  bri_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk_i, .wr_en_i(wr_en), .wr_addr_i(job_i.pixel_index), .wr_data_i(job_i.rgb),
    .rd_addr_i(idx[ADDR_W-1:0]), .rd_data_o(rd_data)
  );

  // Cubic lanes, one per channel; one multiply per step from registers.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 4; k++) begin
        p[ch][k] = pass_q[2] ? cols_q[ch][k]
                             : $signed({{(VAL_W-FRAC_W-8){1'b0}}, samp_q[ch][k], {FRAC_W{1'b0}}});
      end
      case (step_q)
        2'd1:    mul_in[ch] = a_q[ch];
        2'd2:    mul_in[ch] = b_q[ch];
        default: mul_in[ch] = c_q[ch];
      endcase
      prod[ch]  = $signed({1'b0, t_sel}) * mul_in[ch];
      r_val[ch] = p[ch][1] + VAL_W'(prod[ch] >>> (FRAC_W + 1));
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          if (job_i.kind == KIND_REQUEST) state_d = B_READ;
        end
      end
      B_READ: if (cnt_q == 2'd3) state_d = B_LAST;
      B_LAST: state_d = B_CUB;
      B_CUB: begin
        if (step_q == 2'd3) begin
          if (pass_q[2]) state_d = B_OUT;
          else if (pass_q[1:0] == 2'd3) state_d = B_CUB;
          else state_d = B_READ;
        end
      end
      B_OUT: if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      pass_q   <= '0;
      cnt_q    <= '0;
      step_q   <= '0;
      rd_vld_q <= 1'b0;
      out_vq   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= state_q == B_READ;
      if (state_q == B_OUT && out_free) out_vq <= 1'b1;
      else if (out_ready_i) out_vq <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          pass_q <= '0;
          cnt_q  <= '0;
          step_q <= '0;
        end
        B_READ: cnt_q <= cnt_q + 1'b1;
        B_CUB: begin
          step_q <= step_q + 1'b1;
          if (step_q == 2'd3) pass_q <= pass_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_n_q <= cnt_q;
    if (pop_o && job_i.kind == KIND_REQUEST) begin
      gxi_q <= job_i.gx[POS_W-1:FRAC_W];
      gyi_q <= job_i.gy[POS_W-1:FRAC_W];
      tx_q  <= job_i.gx[FRAC_W-1:0];
      ty_q  <= job_i.gy[FRAC_W-1:0];
    end
    if (rd_vld_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        samp_q[ch][rd_n_q] <= rd_data[PIX_W-1-8*ch -: 8];
      end
    end
    if (state_q == B_CUB) begin
      for (int ch = 0; ch < 3; ch++) begin
        case (step_q)
          2'd0: a_q[ch] <= 3 * (p[ch][1] - p[ch][2]) + p[ch][3] - p[ch][0];
          2'd1: b_q[ch] <= 2 * p[ch][0] - 5 * p[ch][1] + 4 * p[ch][2] - p[ch][3]
                           + VAL_W'(prod[ch] >>> FRAC_W);
          2'd2: c_q[ch] <= p[ch][2] - p[ch][0] + VAL_W'(prod[ch] >>> FRAC_W);
          default: begin
            if (pass_q[2]) res_q[ch] <= sat8(r_val[ch]);
            else cols_q[ch][pass_q[1:0]] <= r_val[ch];
          end
        endcase
      end
    end
    if (state_q == B_OUT && out_free) begin
      for (int ch = 0; ch < 3; ch++) out_q[ch] <= res_q[ch];
    end
  end

  assign out_valid_o = out_vq;
  assign red_out_o   = out_q[0];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[2];
endmodule

// ===== sv/bicubic_rgb_image_resize_top.sv =====
`timescale 1ns / 1ps
// Bicubic (Catmull-Rom) RGB888 resizer, top level: configuration registers,
// front end, job queue and back end. Depends on bri_pkg and all bri_ modules.
//
// Send load words (kind 0) to fill the 64K-entry source store at y*src_width+x,
// then request words (kind 1) with an output (x, y); each request returns one
// RGB word, loads return nothing. A request holds the front end while it is
// accepted, while the coordinate dividers run (one quotient bit a cycle), while
// it sees them finish and until the job is queued. The back end pops a request,
// makes four column passes of four store reads (the single read port gives one
// neighbour a cycle), each followed by a wait for the registered read data and
// four cubic steps, then a four-step pass along x, and moves the result to the
// output register once it is free. A load passes the front end's accept and
// push states and is written to the store as the back end pops it. Front and
// back run concurrently through a two-entry queue, so steady request throughput
// is set by the back end, lower while the output is stalled. The output
// register holds a finished word while new words are still taken.
// Sizes are saturated to 1..256 (source) and 1..1024 (destination); write them
// only while the block is idle. Never read a store entry that was not loaded.
module bicubic_rgb_image_resize_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [15:0] pixel_index_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [9:0]  out_x_i,
  input  logic [9:0]  out_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o
);
  import bri_pkg::*;

  cfg_t cfg_q, cfg_sat;
  job_t push_job, pop_job;
  logic push, full, pop, job_valid;

  function automatic logic [SRC_W-1:0] sat_src(input logic [SRC_W-1:0] v);
    if (v == '0) return SRC_W'(1);
    if (v > SRC_W'(MAX_SRC_DIM)) return SRC_W'(MAX_SRC_DIM);
    return v;
  endfunction

  function automatic logic [DEST_W-1:0] sat_dest(input logic [DEST_W-1:0] v);
    if (v == '0) return DEST_W'(1);
    if (v > DEST_W'(MAX_DEST_DIM)) return DEST_W'(MAX_DEST_DIM);
    return v;
  endfunction

  // Configuration is always accepted; unknown indexes drop.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width   <= SRC_W'(MAX_SRC_DIM);
      cfg_q.src_height  <= SRC_W'(MAX_SRC_DIM);
      cfg_q.dest_width  <= DEST_W'(256);
      cfg_q.dest_height <= DEST_W'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SRC_WIDTH:   cfg_q.src_width   <= cfg_data_i[SRC_W-1:0];
        REG_SRC_HEIGHT:  cfg_q.src_height  <= cfg_data_i[SRC_W-1:0];
        REG_DEST_WIDTH:  cfg_q.dest_width  <= cfg_data_i[DEST_W-1:0];
        REG_DEST_HEIGHT: cfg_q.dest_height <= cfg_data_i[DEST_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold sizes in their legal ranges for the datapath.
  assign cfg_sat.src_width   = sat_src(cfg_q.src_width);
  assign cfg_sat.src_height  = sat_src(cfg_q.src_height);
  assign cfg_sat.dest_width  = sat_dest(cfg_q.dest_width);
  assign cfg_sat.dest_height = sat_dest(cfg_q.dest_height);

  bri_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_sat), .in_valid_i, .in_ready_o, .kind_i,
    .pixel_index_i, .red_in_i, .green_in_i, .blue_in_i, .out_x_i, .out_y_i,
    .push_o(push), .job_o(push_job), .full_i(full)
  );

  bri_fifo u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(push_job), .full_o(full),
    .pop_i(pop), .valid_o(job_valid), .job_o(pop_job)
  );

  bri_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_sat), .job_valid_i(job_valid), .job_i(pop_job),
    .pop_o(pop), .out_valid_o, .out_ready_i, .red_out_o, .green_out_o, .blue_out_o
  );
endmodule

// ===== tb/bicubic_rgb_image_resize_checker.sv =====
`timescale 1ns / 1ps
// Checker for the bicubic RGB resizer: watches the config, input and output
// channels, predicts each output word and compares it. Depends on bri_pkg.
module bicubic_rgb_image_resize_checker
  import bri_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        kind_i,
  input  logic [15:0] pixel_index_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [9:0]  out_x_i,
  input  logic [9:0]  out_y_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  red_out_i,
  input  logic [7:0]  green_out_i,
  input  logic [7:0]  blue_out_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [PIX_W-1:0]  pixel_mem [STORE_DEPTH];
  logic [SRC_W-1:0]  src_w_q, src_h_q;
  logic [DEST_W-1:0] dest_w_q, dest_h_q;
  logic [PIX_W-1:0]  expected_rgb [$];
  int                mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_rgb.size();

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint catmull_rom(longint p0, longint p1, longint p2, longint p3,
                                         longint t);
    longint a, b, c;
    a = 3 * (p1 - p2) + p3 - p0;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3 + ((t * a) >>> 16);
    c = p2 - p0 + ((t * b) >>> 16);
    return p1 + ((t * c) >>> 17);
  endfunction

  function automatic logic [PIX_W-1:0] resample_pixel(logic [9:0] ox, logic [9:0] oy);
    longint sw, sh, dw, dh, gx, gy, px, py, r;
    longint samp [4];
    longint col [4];
    logic [PIX_W-1:0] rgb;
    sw = clip(src_w_q, 1, MAX_SRC_DIM);
    sh = clip(src_h_q, 1, MAX_SRC_DIM);
    dw = clip(dest_w_q, 1, MAX_DEST_DIM);
    dh = clip(dest_h_q, 1, MAX_DEST_DIM);
    gx = ((longint'(ox) * (sw - 1)) << 16) / dw;
    gy = ((longint'(oy) * (sh - 1)) << 16) / dh;
    for (int ch = 0; ch < 3; ch++) begin
      for (int m = 0; m < 4; m++) begin
        px = clip((gx >> 16) + m - 1, 0, sw - 1);
        for (int n = 0; n < 4; n++) begin
          py = clip((gy >> 16) + n - 1, 0, sh - 1);
          samp[n] = longint'(pixel_mem[(py * sw + px) % STORE_DEPTH][16-8*ch +: 8]) << 16;
        end
        col[m] = catmull_rom(samp[0], samp[1], samp[2], samp[3], gy & 'hFFFF);
      end
      r = catmull_rom(col[0], col[1], col[2], col[3], gx & 'hFFFF);
      rgb[16-8*ch +: 8] = (r < 0) ? 8'd0 : 8'(clip(r >>> 16, 0, 255));
    end
    return rgb;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [PIX_W-1:0] want, got;
    if (!rst_ni) begin
      src_w_q    <= SRC_W'(256);
      src_h_q    <= SRC_W'(256);
      dest_w_q   <= DEST_W'(256);
      dest_h_q   <= DEST_W'(256);
      mismatches <= 0;
      expected_rgb.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SRC_WIDTH: begin
            src_w_q <= cfg_data_i[SRC_W-1:0];
          end
          REG_SRC_HEIGHT: begin
            src_h_q <= cfg_data_i[SRC_W-1:0];
          end
          REG_DEST_WIDTH: begin
            dest_w_q <= cfg_data_i[DEST_W-1:0];
          end
          REG_DEST_HEIGHT: begin
            dest_h_q <= cfg_data_i[DEST_W-1:0];
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (kind_i == KIND_LOAD) begin
          pixel_mem[pixel_index_i] = {red_in_i, green_in_i, blue_in_i};
        end else begin
          expected_rgb.push_back(resample_pixel(out_x_i, out_y_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        got = {red_out_i, green_out_i, blue_out_i};
        if (expected_rgb.size() == 0) begin
          if (mismatches < 10) $display("unexpected output word rgb=%h", got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_rgb.pop_front();
          if (want !== got) begin
            if (mismatches < 10)
              $display("output word wrong: red %0d/%0d green %0d/%0d blue %0d/%0d (exp/got)",
                       want[23:16], got[23:16], want[15:8], got[15:8], want[7:0], got[7:0]);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/bicubic_rgb_image_resize_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the bicubic RGB resizer: drives config, load and request
// words and gives the verdict. Depends on bri_pkg, the block and the checker.
module bicubic_rgb_image_resize_top_test;
  import bri_pkg::*;

  // Index outside the register list; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd200;
  localparam int DRAIN_CYCLES = 150;

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i, in_ready_o, kind_i;
  logic [15:0] pixel_index_i;
  logic [7:0]  red_in_i, green_in_i, blue_in_i;
  logic [9:0]  out_x_i, out_y_i;
  logic        out_valid_o, out_ready_i;
  logic [7:0]  red_out_o, green_out_o, blue_out_o;
  int          fail_count, pending;
  int          sender_idle_pct, receiver_stall_pct;
  int          loads_sent, requests_sent;

  bicubic_rgb_image_resize_top dut (.*);

  bicubic_rgb_image_resize_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .pixel_index_i,
    .red_in_i, .green_in_i, .blue_in_i, .out_x_i, .out_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .red_out_i(red_out_o),
    .green_out_i(green_out_o), .blue_out_i(blue_out_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop, well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("bicubic_rgb_image_resize_top: mismatch");
    $finish;
  end

  // Receiver: stall at random according to the current phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Write one register; drop valid in the step of acceptance, then wait for the
  // next clock edge so the next write raises it in a fresh step.
  task automatic write_reg(logic [7:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Present one word. Valid is left high after acceptance so back-to-back
  // words need no toggle; it is dropped only when the sender idles.
  task automatic send_word(logic kind, logic [15:0] idx, logic [23:0] rgb,
                           logic [9:0] x, logic [9:0] y);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    pixel_index_i <= idx;
    {red_in_i, green_in_i, blue_in_i} <= rgb;
    out_x_i       <= x;
    out_y_i       <= y;
    do @(posedge clk_i); while (!in_ready_o);
    if (kind == KIND_LOAD) loads_sent++;
    else requests_sent++;
  endtask

  // Hold the sender until every expected word is back, then let the block
  // settle (a trailing load returns nothing).
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
      default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
    endcase
  endtask

  // One phase: write the sizes as given (raw, possibly out of range), load
  // every source pixel the sizes can reach, then mostly requests.
  task automatic run_phase(int sw_raw, int sh_raw, int dw_raw, int dh_raw,
                           int mode, bit extremes, int n_random);
    int sw, sh;
    logic [23:0] rgb;
    sw = sw_raw & 'h1FF;
    sh = sh_raw & 'h1FF;
    sw = (sw < 1) ? 1 : (sw > MAX_SRC_DIM) ? MAX_SRC_DIM : sw;
    sh = (sh < 1) ? 1 : (sh > MAX_SRC_DIM) ? MAX_SRC_DIM : sh;
    write_reg(REG_SRC_WIDTH, 16'(sw_raw));
    write_reg(REG_SRC_HEIGHT, 16'(sh_raw));
    write_reg(REG_DEST_WIDTH, 16'(dw_raw));
    write_reg(REG_DEST_HEIGHT, 16'(dh_raw));
    set_idling(mode);
    for (int i = 0; i < sw * sh; i++) begin
      // Hard edges, each channel all zeros or all ones, push the cubic over- and undershoot into saturation.
      if (extremes)
        rgb = {{8{i[0] ^ i[3]}}, {8{i[1]}}, {8{~i[0]}}};
      else
        rgb = 24'($urandom);
      send_word(KIND_LOAD, 16'(i), rgb, 10'($urandom), 10'($urandom));
    end
    for (int i = 0; i < n_random; i++) begin
      if ($urandom_range(99) < 15)
        send_word(KIND_LOAD, 16'($urandom), 24'($urandom), 10'($urandom),
                  10'($urandom));
      else if ($urandom_range(99) < 70)
        send_word(KIND_REQUEST, 16'($urandom), 24'($urandom),
                  10'($urandom_range(dw_raw > 1023 ? 1023 : dw_raw)),
                  10'($urandom_range(dh_raw > 1023 ? 1023 : dh_raw)));
      else
        send_word(KIND_REQUEST, 16'($urandom), 24'($urandom), 10'($urandom),
                  10'($urandom));
    end
    drain();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    kind_i        <= KIND_LOAD;
    pixel_index_i <= '0;
    red_in_i      <= '0;
    green_in_i    <= '0;
    blue_in_i     <= '0;
    out_x_i       <= '0;
    out_y_i       <= '0;
    loads_sent     = 0;
    requests_sent  = 0;
    set_idling(0);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a 4x4 image of hard edges, corner and out-of-range requests,
    // the top store address and an ignored register index.
    run_phase(4, 4, 8, 8, 0, 1'b1, 0);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_word(KIND_LOAD, 16'hFFFF, 24'hFFFFFF, 10'h3FF, 10'h3FF);
    send_word(KIND_LOAD, 16'hFFFE, 24'h000000, 10'h000, 10'h000);
    send_word(KIND_REQUEST, 16'h0000, 24'h000000, 10'd0, 10'd0);
    send_word(KIND_REQUEST, 16'hFFFF, 24'hFFFFFF, 10'h3FF, 10'h3FF);
    send_word(KIND_REQUEST, 16'h0000, 24'h000000, 10'h3FF, 10'd0);
    send_word(KIND_REQUEST, 16'h0000, 24'h000000, 10'd0, 10'h3FF);
    send_word(KIND_REQUEST, 16'h0000, 24'h000000, 10'd7, 10'd7);
    send_word(KIND_REQUEST, 16'h0000, 24'h000000, 10'd3, 10'd5);
    send_word(KIND_REQUEST, 16'h0000, 24'h000000, 10'd8, 10'd1);
    send_word(KIND_REQUEST, 16'h0000, 24'h000000, 10'd5, 10'd2);
    drain();

    // Random phases over idling modes and size extremes, zero and oversized
    // register values among them.
    run_phase(4, 4, 1024, 1, 0, 1'b1, 80);
    run_phase(256, 1, 1024, 3, 1, 1'b0, 80);
    run_phase(0, 256, 0, 1024, 2, 1'b1, 80);
    run_phase(7, 5, 3, 1000, 3, 1'b0, 90);
    run_phase(16, 8, 33, 17, 0, 1'b0, 90);
    run_phase(0, 0, 2047, 5, 1, 1'b0, 50);
    run_phase(511, 0, 1, 2047, 3, 1'b1, 80);
    run_phase(13, 9, 640, 480, 2, 1'b0, 90);

    $display("covered %0d load words and %0d requests over nine size settings",
             loads_sent, requests_sent);
    $display("idling modes: none, sender, receiver and both sides");
    if (fail_count == 0 && pending == 0) begin
      $display("bicubic_rgb_image_resize_top: match");
    end else begin
      $display("bicubic_rgb_image_resize_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bri_pkg.sv
sv/bri_ram.sv
sv/bri_div.sv
sv/bri_front.sv
sv/bri_fifo.sv
sv/bri_back.sv
sv/bicubic_rgb_image_resize_top.sv
tb/bicubic_rgb_image_resize_checker.sv
tb/bicubic_rgb_image_resize_top_test.sv
